### sv/energy_voice_activity_segmenter_macros.svh
// assertion macros for the energy voice activity segmenter
// used by modules that check their own sequencing; expects clk and rst_n in scope
`ifndef ENERGY_VOICE_ACTIVITY_SEGMENTER_MACROS_SVH
`define ENERGY_VOICE_ACTIVITY_SEGMENTER_MACROS_SVH

// same-cycle implication
`define EVAS_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define EVAS_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### sv/evas_pkg.sv
// shared types, constants and helpers of the energy voice activity segmenter
// no dependencies; used by the divider and the top level
package evas_pkg;

    localparam int CAL_BLOCKS_DEF = 256;
    localparam int BLOCK_MAX_DEF  = 65535;

    localparam int SAMPLE_W = 16;
    localparam int VAL_W    = 24;
    localparam int BCNT_W   = 16;
    localparam int SUM_W    = 32;
    localparam int FRAC_W   = 8;
    localparam int DIVD_W   = SUM_W + FRAC_W;
    localparam int GAIN_W   = 16;
    localparam int RATIO_W  = 9;
    localparam int PROD_W   = VAL_W + GAIN_W;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // register indexes
    localparam logic [2:0] REG_FLOOR   = 3'd0;
    localparam logic [2:0] REG_GAIN    = 3'd1;
    localparam logic [2:0] REG_RATIO   = 3'd2;
    localparam logic [2:0] REG_CAL_LEN = 3'd3;
    localparam logic [2:0] REG_SIL_TO  = 3'd4;
    localparam logic [2:0] REG_MAX_LEN = 3'd5;
    localparam logic [2:0] REG_PREROLL = 3'd6;

    // reset values of the registers
    localparam logic [VAL_W-1:0]   FLOOR_RST   = 24'd2560;
    localparam logic [GAIN_W-1:0]  GAIN_RST    = 16'd768;
    localparam logic [RATIO_W-1:0] RATIO_RST   = 9'd179;
    localparam logic [VAL_W-1:0]   CAL_LEN_RST = 24'd16000;
    localparam logic [VAL_W-1:0]   SIL_TO_RST  = 24'd12800;
    localparam logic [VAL_W-1:0]   MAX_LEN_RST = 24'd160000;
    localparam logic [VAL_W-1:0]   PREROLL_RST = 24'd4800;

    typedef enum logic [2:0] {
        EVT_CALIB   = 3'd0,
        EVT_IDLE    = 3'd1,
        EVT_START   = 3'd2,
        EVT_SPEAK   = 3'd3,
        EVT_END_SIL = 3'd4,
        EVT_END_LEN = 3'd5
    } event_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // saturating 24-bit add
    function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VAL_W] ? {VAL_W{1'b1}} : s[VAL_W-1:0];
    endfunction

endpackage

### sv/energy_voice_activity_segmenter.sv
// Energy voice activity segmenter: samples stream in on the s_ channel
// (s_tdata = sample, s_tlast = last sample of a block). One decision per
// block leaves on the m_ channel; m_tuser carries the event code.
// Registers are written over the APB port; the user must write them only
// while the block is idle, which the block itself does not enforce.
// A sample that does not close a block is taken while idle; a block-ending
// sample is accepted, then the bit-serial mean divider runs its steps and
// signals done, then one multiply for the hysteresis level, the decision
// and the output load follow before the next sample is taken.
// At the block that ends calibration, the 90th-percentile energy is found
// by a selection pass over the calibration ram, a read and a compare per
// entry scanned, for n kept energies (n up to CAL_BLOCKS), plus a gain
// multiply and the floor compare.
// The result waits in an output register; samples are still accepted while
// it waits, and only a new block end stalls until m_tready takes it.
// Reset restores register defaults, restarts calibration, clears counts;
// the ram needs no clearing since only written entries are read.
// depends on evas_pkg, evas_div, evas_ram and the assertion macro header
`include "energy_voice_activity_segmenter_macros.svh"

module energy_voice_activity_segmenter #(
    parameter int CAL_BLOCKS = evas_pkg::CAL_BLOCKS_DEF,
    parameter int BLOCK_MAX  = evas_pkg::BLOCK_MAX_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [evas_pkg::ADDR_W-1:0]      paddr,
    input  logic [evas_pkg::DATA_W-1:0]      pwdata,
    output logic [evas_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    // sample input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic signed [15:0]               s_tdata,   // sample
    input  logic                             s_tlast,
    // decision output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // block_energy[23:0], speech_threshold[47:24], block_samples[63:48],
    // preroll_prepended[87:64], phrase_samples[111:88]
    output logic [111:0]                     m_tdata,
    output logic [2:0]                       m_tuser    // event_res
);

    localparam int VW    = evas_pkg::VAL_W;
    localparam int AW    = CAL_BLOCKS > 1 ? $clog2(CAL_BLOCKS) : 1;
    localparam int CNT_W = $clog2(CAL_BLOCKS + 1);
    localparam int XW    = CNT_W + 4;
    localparam int KW    = XW + 16;
    localparam logic [15:0] RECIP10 = 16'd52429;  // 2^19 / 10 rounded up

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_HANG,
        ST_DECIDE,
        ST_SEL_RD,
        ST_SEL_CAND,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SEL_CHK,
        ST_CAL_MUL,
        ST_CAL_THR,
        ST_EMIT
    } state_t;

    // configuration registers
    logic [VW-1:0]                  floor_reg;
    logic [evas_pkg::GAIN_W-1:0]    gain_reg;
    logic [evas_pkg::RATIO_W-1:0]   ratio_reg;
    logic [VW-1:0]                  cal_len_reg;
    logic [VW-1:0]                  sil_to_reg;
    logic [VW-1:0]                  max_len_reg;
    logic [VW-1:0]                  preroll_len_reg;

    // control and detector state
    state_t                         state_reg;
    logic                           calibrating_reg;
    logic                           speaking_reg;
    logic [VW-1:0]                  thr_reg;
    logic [CNT_W-1:0]               cal_count_reg;
    logic [VW-1:0]                  cal_seen_reg;
    logic [VW-1:0]                  held_reg;
    logic [VW-1:0]                  quiet_reg;
    logic [VW-1:0]                  phrase_reg;
    logic [evas_pkg::SUM_W-1:0]     sum_reg;
    logic [evas_pkg::BCNT_W-1:0]    bcnt_reg;
    logic [evas_pkg::BCNT_W-1:0]    n_reg;
    logic [VW-1:0]                  energy_reg;
    logic [evas_pkg::PROD_W-1:0]    prod_reg;
    logic [CNT_W-1:0]               sel_i_reg;
    logic [CNT_W-1:0]               scan_j_reg;
    logic [CNT_W-1:0]               less_reg;
    logic [CNT_W-1:0]               le_reg;
    logic [CNT_W-1:0]               k_reg;
    logic [VW-1:0]                  cand_reg;
    logic [VW-1:0]                  amb_reg;
    evas_pkg::event_t               res_evt_reg;
    logic [VW-1:0]                  res_prep_reg;
    logic [VW-1:0]                  res_plen_reg;

    // output registers
    logic                           m_tvalid_reg;
    evas_pkg::event_t               out_evt_reg;
    logic [VW-1:0]                  out_energy_reg;
    logic [VW-1:0]                  out_thr_reg;
    logic [evas_pkg::BCNT_W-1:0]    out_n_reg;
    logic [VW-1:0]                  out_prep_reg;
    logic [VW-1:0]                  out_plen_reg;

    logic                           cfg_wr;
    logic                           in_acc;
    logic [16:0]                    mag;
    logic                           add_ok;
    logic [evas_pkg::SUM_W-1:0]     sum_new;
    logic [evas_pkg::BCNT_W-1:0]    bcnt_new;
    logic                           div_start;
    logic [VW-1:0]                  div_quo;
    evas_pkg::div_stat_t            div_stat;
    logic [VW-1:0]                  mul_a;
    logic [evas_pkg::GAIN_W-1:0]    mul_b;
    logic [evas_pkg::PROD_W-1:0]    mul_out;
    logic                           ram_we;
    logic [AW-1:0]                  ram_raddr;
    logic [VW-1:0]                  ram_rdata;
    logic                           emit_ok;

    // decision signals
    logic [VW-1:0]                  n24;
    logic [VW:0]                    hang;
    logic                           cal_room;
    logic [CNT_W-1:0]               cal_count_new;
    logic [VW-1:0]                  cal_seen_new;
    logic [VW-1:0]                  held_add;
    logic [VW-1:0]                  phrase_start_len;
    logic [VW-1:0]                  phrase_cont_len;
    logic [VW-1:0]                  quiet_add;
    evas_pkg::event_t               speak_evt;
    logic [XW-1:0]                  k_x;
    logic [KW-1:0]                  k_prod;
    logic [VW+8-1:0]                thr_raw;
    logic [VW-1:0]                  thr_sat;

    // preroll count update, held to the configured length
    function automatic logic [VW-1:0] preroll_upd(input logic [VW-1:0] held,
                                                  input logic [VW-1:0] n,
                                                  input logic [VW-1:0] len);
        logic [VW-1:0] s;
        s = evas_pkg::sat_add(held, n);
        if (len == '0)
        begin
            return held;
        end
        return (s > len) ? len : s;
    endfunction

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg       <= evas_pkg::FLOOR_RST;
            gain_reg        <= evas_pkg::GAIN_RST;
            ratio_reg       <= evas_pkg::RATIO_RST;
            cal_len_reg     <= evas_pkg::CAL_LEN_RST;
            sil_to_reg      <= evas_pkg::SIL_TO_RST;
            max_len_reg     <= evas_pkg::MAX_LEN_RST;
            preroll_len_reg <= evas_pkg::PREROLL_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                evas_pkg::REG_FLOOR:   floor_reg       <= pwdata[VW-1:0];
                evas_pkg::REG_GAIN:    gain_reg        <= pwdata[evas_pkg::GAIN_W-1:0];
                evas_pkg::REG_RATIO:   ratio_reg       <= pwdata[evas_pkg::RATIO_W-1:0];
                evas_pkg::REG_CAL_LEN: cal_len_reg     <= pwdata[VW-1:0];
                evas_pkg::REG_SIL_TO:  sil_to_reg      <= pwdata[VW-1:0];
                evas_pkg::REG_MAX_LEN: max_len_reg     <= pwdata[VW-1:0];
                evas_pkg::REG_PREROLL: preroll_len_reg <= pwdata[VW-1:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (paddr[4:2])
            evas_pkg::REG_FLOOR:   prdata = {8'd0, floor_reg};
            evas_pkg::REG_GAIN:    prdata = {16'd0, gain_reg};
            evas_pkg::REG_RATIO:   prdata = {23'd0, ratio_reg};
            evas_pkg::REG_CAL_LEN: prdata = {8'd0, cal_len_reg};
            evas_pkg::REG_SIL_TO:  prdata = {8'd0, sil_to_reg};
            evas_pkg::REG_MAX_LEN: prdata = {8'd0, max_len_reg};
            evas_pkg::REG_PREROLL: prdata = {8'd0, preroll_len_reg};
            default:               prdata = '0;
        endcase
    end

    // sample magnitude and accumulation
    always_comb
    begin
        mag      = s_tdata[15] ? (17'h10000 - {1'b0, s_tdata}) : {1'b0, s_tdata};
        add_ok   = bcnt_reg < 16'(BLOCK_MAX);
        sum_new  = add_ok ? (sum_reg + {15'd0, mag}) : sum_reg;
        bcnt_new = add_ok ? (bcnt_reg + 1'b1) : bcnt_reg;
        div_start = in_acc && s_tlast;
    end

    evas_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_new, 8'h00}),
        .divisor  (bcnt_new),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // shared multiplier: hysteresis level or gain times ambient
    always_comb
    begin
        mul_a   = (state_reg == ST_CAL_MUL) ? amb_reg : thr_reg;
        mul_b   = (state_reg == ST_CAL_MUL) ? gain_reg : {7'd0, ratio_reg};
        mul_out = {16'd0, mul_a} * {24'd0, mul_b};
    end

    // calibration energy store
    assign ram_we    = (state_reg == ST_DECIDE) && calibrating_reg && cal_room;
    assign ram_raddr = (state_reg == ST_SEL_RD) ? sel_i_reg[AW-1:0] : scan_j_reg[AW-1:0];

    evas_ram #(
        .WIDTH (VW),
        .DEPTH (CAL_BLOCKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cal_count_reg[AW-1:0]),
        .wdata (energy_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // block decision terms
    always_comb
    begin
        n24              = {8'd0, n_reg};
        hang             = prod_reg[VW+8:8];
        cal_room         = cal_count_reg < CNT_W'(CAL_BLOCKS);
        cal_count_new    = cal_room ? (cal_count_reg + 1'b1) : cal_count_reg;
        cal_seen_new     = evas_pkg::sat_add(cal_seen_reg, n24);
        held_add         = preroll_upd(held_reg, n24, preroll_len_reg);
        phrase_start_len = evas_pkg::sat_add(held_reg, n24);
        phrase_cont_len  = evas_pkg::sat_add(phrase_reg, n24);
        quiet_add        = evas_pkg::sat_add(quiet_reg, n24);
        if ({1'b0, energy_reg} > hang)
        begin
            speak_evt = evas_pkg::EVT_SPEAK;
        end
        else if (quiet_add >= sil_to_reg)
        begin
            speak_evt = evas_pkg::EVT_END_SIL;
        end
        else
        begin
            speak_evt = evas_pkg::EVT_SPEAK;
        end
        if (speak_evt == evas_pkg::EVT_SPEAK && phrase_cont_len >= max_len_reg)
        begin
            speak_evt = evas_pkg::EVT_END_LEN;
        end
        // percentile rank floor((count-1)*9/10) by reciprocal multiply
        k_x     = XW'(cal_count_new - 1'b1) * XW'(9);
        k_prod  = KW'(k_x) * KW'(RECIP10);
        thr_raw = prod_reg[evas_pkg::PROD_W-1:8];
        thr_sat = (|thr_raw[VW+7:VW]) ? {VW{1'b1}} : thr_raw[VW-1:0];
    end

    assign emit_ok = !m_tvalid_reg || m_tready;

    // sequencer, detector state and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            calibrating_reg <= 1'b1;
            speaking_reg    <= 1'b0;
            thr_reg         <= evas_pkg::FLOOR_RST;
            cal_count_reg   <= '0;
            cal_seen_reg    <= '0;
            held_reg        <= '0;
            quiet_reg       <= '0;
            phrase_reg      <= '0;
            sum_reg         <= '0;
            bcnt_reg        <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            // output valid: set on a load, cleared when taken
            if (state_reg == ST_EMIT && emit_ok)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (s_tlast)
                        begin
                            n_reg     <= bcnt_new;
                            sum_reg   <= '0;
                            bcnt_reg  <= '0;
                            state_reg <= ST_DIV;
                        end
                        else
                        begin
                            sum_reg  <= sum_new;
                            bcnt_reg <= bcnt_new;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        energy_reg <= div_quo;
                        state_reg  <= ST_HANG;
                    end
                end
                ST_HANG:
                begin
                    prod_reg  <= mul_out;
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    state_reg <= ST_EMIT;
                    if (calibrating_reg)
                    begin
                        res_evt_reg   <= evas_pkg::EVT_CALIB;
                        res_prep_reg  <= '0;
                        res_plen_reg  <= '0;
                        cal_count_reg <= cal_count_new;
                        cal_seen_reg  <= cal_seen_new;
                        held_reg      <= held_add;
                        if (cal_seen_new >= cal_len_reg)
                        begin
                            calibrating_reg <= 1'b0;
                            sel_i_reg       <= '0;
                            k_reg           <= CNT_W'(k_prod >> 19);
                            amb_reg         <= '0;
                            state_reg       <= (cal_count_new != '0) ? ST_SEL_RD : ST_CAL_MUL;
                        end
                    end
                    else if (!speaking_reg)
                    begin
                        if (energy_reg > thr_reg)
                        begin
                            res_evt_reg  <= evas_pkg::EVT_START;
                            res_prep_reg <= held_reg;
                            res_plen_reg <= phrase_start_len;
                            speaking_reg <= 1'b1;
                            quiet_reg    <= '0;
                            phrase_reg   <= phrase_start_len;
                            held_reg     <= '0;
                        end
                        else
                        begin
                            res_evt_reg  <= evas_pkg::EVT_IDLE;
                            res_prep_reg <= '0;
                            res_plen_reg <= '0;
                            held_reg     <= held_add;
                        end
                    end
                    else
                    begin
                        res_evt_reg  <= speak_evt;
                        res_prep_reg <= '0;
                        res_plen_reg <= phrase_cont_len;
                        if (speak_evt != evas_pkg::EVT_SPEAK)
                        begin
                            speaking_reg <= 1'b0;
                            quiet_reg    <= '0;
                            phrase_reg   <= '0;
                        end
                        else
                        begin
                            phrase_reg <= phrase_cont_len;
                            quiet_reg  <= ({1'b0, energy_reg} > hang) ? '0 : quiet_add;
                        end
                    end
                end
                ST_SEL_RD:
                begin
                    state_reg <= ST_SEL_CAND;
                end
                ST_SEL_CAND:
                begin
                    cand_reg   <= ram_rdata;
                    scan_j_reg <= '0;
                    less_reg   <= '0;
                    le_reg     <= '0;
                    state_reg  <= ST_SCAN_RD;
                end
                ST_SCAN_RD:
                begin
                    state_reg <= ST_SCAN_CMP;
                end
                ST_SCAN_CMP:
                begin
                    if (ram_rdata < cand_reg)
                    begin
                        less_reg <= less_reg + 1'b1;
                    end
                    if (ram_rdata <= cand_reg)
                    begin
                        le_reg <= le_reg + 1'b1;
                    end
                    if (scan_j_reg == cal_count_reg - 1'b1)
                    begin
                        state_reg <= ST_SEL_CHK;
                    end
                    else
                    begin
                        scan_j_reg <= scan_j_reg + 1'b1;
                        state_reg  <= ST_SCAN_RD;
                    end
                end
                ST_SEL_CHK:
                begin
                    // candidate sits at the rank when enough values fall at or below it
                    if (less_reg <= k_reg && k_reg < le_reg)
                    begin
                        amb_reg   <= cand_reg;
                        state_reg <= ST_CAL_MUL;
                    end
                    else
                    begin
                        sel_i_reg <= sel_i_reg + 1'b1;
                        state_reg <= ST_SEL_RD;
                    end
                end
                ST_CAL_MUL:
                begin
                    prod_reg  <= mul_out;
                    state_reg <= ST_CAL_THR;
                end
                ST_CAL_THR:
                begin
                    thr_reg   <= (thr_sat > floor_reg) ? thr_sat : floor_reg;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (emit_ok)
                    begin
                        out_evt_reg    <= res_evt_reg;
                        out_energy_reg <= energy_reg;
                        out_thr_reg    <= thr_reg;
                        out_n_reg      <= n_reg;
                        out_prep_reg   <= res_prep_reg;
                        out_plen_reg   <= res_plen_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_evt_reg;
    assign m_tdata  = {out_plen_reg, out_prep_reg, out_n_reg, out_thr_reg, out_energy_reg};

    // checks on sequencing
    `EVAS_ASSERT_IMP(a_speak_after_cal, speaking_reg, !calibrating_reg,
        "speaking while calibrating")
    `EVAS_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_reg == ST_DIV,
        "divider finished outside the divide step")
    `EVAS_ASSERT_IMP(a_cal_count_max, 1'b1, cal_count_reg <= CNT_W'(CAL_BLOCKS),
        "calibration count beyond capacity")
    `EVAS_ASSERT_NXT(a_emit_waits, state_reg == ST_EMIT && m_tvalid_reg && !m_tready,
        state_reg == ST_EMIT, "result loaded over a pending item")

endmodule

### sv/evas_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module evas_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

### sv/evas_div.sv
// restoring divider, one quotient bit per cycle, for the block mean
// depends on evas_pkg for widths and the status struct
module evas_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [evas_pkg::DIVD_W-1:0]   dividend,
    input  logic [evas_pkg::BCNT_W-1:0]   divisor,
    output logic [evas_pkg::VAL_W-1:0]    quotient,
    output evas_pkg::div_stat_t           stat
);

    localparam int CNT_W = $clog2(evas_pkg::DIVD_W + 1);

    logic [evas_pkg::DIVD_W-1:0]   quo_reg;
    logic [evas_pkg::BCNT_W:0]     rem_reg;
    logic [evas_pkg::BCNT_W-1:0]   dsr_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [evas_pkg::BCNT_W:0]     rem_sh;
    logic                          ge;
    logic [evas_pkg::BCNT_W:0]     rem_next;
    logic [evas_pkg::DIVD_W-1:0]   quo_next;

    // one shift-subtract step
    always_comb
    begin
        rem_sh   = {rem_reg[evas_pkg::BCNT_W-1:0], quo_reg[evas_pkg::DIVD_W-1]};
        ge       = rem_sh >= {1'b0, dsr_reg};
        rem_next = ge ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
        quo_next = {quo_reg[evas_pkg::DIVD_W-2:0], ge};
    end

    // operand and payload registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // step counter and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(evas_pkg::DIVD_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign quotient  = quo_reg[evas_pkg::VAL_W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
